>>> hdl/krta_pkg.sv
// Package for the keyed record table with averages.
// Holds table sizing, field widths, status and function codes and the record type.
// No dependencies; every other file imports it.
package krta_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

  localparam int KEY_W    = 24;
  localparam int CRED_W   = 10;
  localparam int SCORE_W  = 14;
  localparam int STATUS_W = 3;

  localparam int CREDIT_TOTAL_W   = CRED_W + IDX_W;
  localparam int SCORE_TOTAL_W    = SCORE_W + IDX_W;
  localparam int PRODUCT_W        = SCORE_W + CRED_W;
  localparam int WEIGHTED_TOTAL_W = PRODUCT_W + IDX_W;

  // The divider serves both means: the widest dividend and divisor set its size.
  localparam int DIVIDEND_W = WEIGHTED_TOTAL_W;
  localparam int DIVISOR_W  = CREDIT_TOTAL_W;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_UPDATED   = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [CRED_W-1:0]  credits;
    logic [SCORE_W-1:0] score;
  } record_t;

endpackage

>>> hdl/krta_in_if.sv
// Request channel interface of the keyed record table.
// Carries valid, ready and one request; depends on krta_pkg.
interface krta_in_if import krta_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [KEY_W-1:0]   record_key;
  logic [CRED_W-1:0]  record_credits;
  logic [SCORE_W-1:0] record_score;

  modport source (output valid, func, record_key, record_credits, record_score,
                  input ready);
  modport sink   (input valid, func, record_key, record_credits, record_score,
                  output ready);
endinterface

>>> hdl/krta_out_if.sv
// Response channel interface of the keyed record table.
// Carries valid, ready and one result; depends on krta_pkg.
interface krta_out_if import krta_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CRED_W-1:0]   found_credits;
  logic [SCORE_W-1:0]  found_score;
  logic [COUNT_W-1:0]  record_count;
  logic [SCORE_W-1:0]  mean_score;
  logic                mean_valid;
  logic [SCORE_W-1:0]  weighted_mean_score;
  logic                weighted_valid;

  modport source (output valid, status, found_credits, found_score, record_count,
                  mean_score, mean_valid, weighted_mean_score, weighted_valid,
                  input ready);
  modport sink   (input valid, status, found_credits, found_score, record_count,
                  mean_score, mean_valid, weighted_mean_score, weighted_valid,
                  output ready);
endinterface

>>> hdl/keyed_record_table_with_averages_top.sv
// Keyed record table with running mean scores; needs krta_pkg, krta_in_if, krta_out_if,
// krta_record_ram and krta_divider.
// A request runs through the scan, the decision, the sum updates (for an update or a new record)
// and two divisions, plain mean then weighted mean, before its result is registered.
// No new request is taken until the previous one is finished; the finish waits while the last result is unread.
// Reset (rst, synchronous) empties the table by clearing the used bits, count and totals.
module keyed_record_table_with_averages_top import krta_pkg::*; (
  input logic        clk,
  input logic        rst,
  krta_in_if.sink    cmd,
  krta_out_if.source rsp
);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_SCAN      = 4'd1;
  localparam logic [3:0] ST_DRAIN     = 4'd2;
  localparam logic [3:0] ST_DECIDE    = 4'd3;
  localparam logic [3:0] ST_MUL_OLD   = 4'd4;
  localparam logic [3:0] ST_SUB_OLD   = 4'd5;
  localparam logic [3:0] ST_MUL_NEW   = 4'd6;
  localparam logic [3:0] ST_ADD_NEW   = 4'd7;
  localparam logic [3:0] ST_DIV_START = 4'd8;
  localparam logic [3:0] ST_DIV_WAIT  = 4'd9;
  localparam logic [3:0] ST_FINISH    = 4'd10;

  logic [3:0] state;

  // The accepted request is latched for the whole of its processing.
  logic               req_func;
  logic [KEY_W-1:0]   req_key;
  logic [CRED_W-1:0]  req_credits;
  logic [SCORE_W-1:0] req_score;

  // Table state outside the record memory: used bits, count and running sums.
  logic [TABLE_DEPTH-1:0]      used;
  logic [COUNT_W-1:0]          held_count;
  logic [CREDIT_TOTAL_W-1:0]   credit_total;
  logic [SCORE_TOTAL_W-1:0]    score_total;
  logic [WEIGHTED_TOTAL_W-1:0] weighted_total;

  // Scan pipeline: the read issued in one cycle is compared in the next.
  logic [IDX_W-1:0] rd_idx;
  logic             pipe_valid;
  logic             pipe_used;
  logic [IDX_W-1:0] pipe_idx;
  record_t          rd_data;

  logic               have_hit;
  logic               have_free;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   free_idx;
  logic [CRED_W-1:0]  hit_credits;
  logic [SCORE_W-1:0] hit_score;

  // Result being assembled.
  logic [STATUS_W-1:0]  status;
  logic [CRED_W-1:0]    found_credits;
  logic [SCORE_W-1:0]   found_score;
  logic [PRODUCT_W-1:0] product;
  logic [SCORE_W-1:0]   mean;
  logic [SCORE_W-1:0]   wmean;
  logic                 div_sel;

  // Output register; it holds a finished result while the next request is taken.
  logic                rsp_valid;
  logic [STATUS_W-1:0] out_status;
  logic [CRED_W-1:0]   out_credits;
  logic [SCORE_W-1:0]  out_score;
  logic [COUNT_W-1:0]  out_count;
  logic [SCORE_W-1:0]  out_mean;
  logic                out_mean_valid;
  logic [SCORE_W-1:0]  out_wmean;
  logic                out_wmean_valid;

  // Memory write and divider hookup.
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  record_t               wr_data;
  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_quotient;
  logic                  rsp_free;

  assign cmd.ready = (state == ST_IDLE);
  assign rsp_free  = !rsp_valid || rsp.ready;

  // A new record or an update is written in the decision cycle. The scan for
  // the next request starts only after this write, so no forwarding is needed.
  assign wr_en   = (state == ST_DECIDE) && (req_func == FUNC_INSERT) &&
                   (have_hit || have_free);
  assign wr_addr = have_hit ? hit_idx : free_idx;
  assign wr_data = '{key: req_key, credits: req_credits, score: req_score};

  krta_record_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  // One divider serves the plain mean first and the weighted mean second.
  assign div_start    = (state == ST_DIV_START);
  assign div_dividend = div_sel ? weighted_total : DIVIDEND_W'(score_total);
  assign div_divisor  = div_sel ? credit_total : DIVISOR_W'(held_count);

  krta_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      used           <= '0;
      held_count     <= '0;
      credit_total   <= '0;
      score_total    <= '0;
      weighted_total <= '0;
      rd_idx         <= '0;
      pipe_valid     <= 1'b0;
      have_hit       <= 1'b0;
      have_free      <= 1'b0;
      div_sel        <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      // Compare stage of the scan: first matching used slot, first free slot.
      if (pipe_valid) begin
        if (pipe_used) begin
          if (!have_hit && rd_data.key == req_key) begin
            have_hit <= 1'b1;
          end
        end else if (!have_free) begin
          have_free <= 1'b1;
        end
      end
      pipe_valid <= (state == ST_SCAN);

      case (state)
        ST_IDLE: begin
          if (cmd.valid) begin
            state     <= ST_SCAN;
            rd_idx    <= '0;
            have_hit  <= 1'b0;
            have_free <= 1'b0;
          end
        end
        ST_SCAN: begin
          rd_idx <= rd_idx + 1'b1;
          if (rd_idx == IDX_W'(TABLE_DEPTH - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          div_sel <= 1'b0;
          if (req_func == FUNC_INSERT) begin
            if (have_hit) begin
              state <= ST_MUL_OLD;
            end else if (have_free) begin
              used[free_idx] <= 1'b1;
              held_count     <= held_count + 1'b1;
              state          <= ST_MUL_NEW;
            end else begin
              state <= ST_DIV_START;
            end
          end else begin
            state <= ST_DIV_START;
          end
        end
        ST_MUL_OLD: begin
          credit_total <= credit_total - CREDIT_TOTAL_W'(hit_credits);
          score_total  <= score_total - SCORE_TOTAL_W'(hit_score);
          state        <= ST_SUB_OLD;
        end
        ST_SUB_OLD: begin
          weighted_total <= weighted_total - WEIGHTED_TOTAL_W'(product);
          state          <= ST_MUL_NEW;
        end
        ST_MUL_NEW: begin
          credit_total <= credit_total + CREDIT_TOTAL_W'(req_credits);
          score_total  <= score_total + SCORE_TOTAL_W'(req_score);
          state        <= ST_ADD_NEW;
        end
        ST_ADD_NEW: begin
          weighted_total <= weighted_total + WEIGHTED_TOTAL_W'(product);
          state          <= ST_DIV_START;
        end
        ST_DIV_START: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            if (div_sel) begin
              state <= ST_FINISH;
            end else begin
              div_sel <= 1'b1;
              state   <= ST_DIV_START;
            end
          end
        end
        ST_FINISH: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers that need no reset.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd.valid) begin
      req_func    <= cmd.func;
      req_key     <= cmd.record_key;
      req_credits <= cmd.record_credits;
      req_score   <= cmd.record_score;
    end

    pipe_idx  <= rd_idx;
    pipe_used <= used[rd_idx];

    if (pipe_valid) begin
      if (pipe_used) begin
        if (!have_hit && rd_data.key == req_key) begin
          hit_idx     <= pipe_idx;
          hit_credits <= rd_data.credits;
          hit_score   <= rd_data.score;
        end
      end else if (!have_free) begin
        free_idx <= pipe_idx;
      end
    end

    if (state == ST_DECIDE) begin
      found_credits <= '0;
      found_score   <= '0;
      if (req_func == FUNC_INSERT) begin
        if (have_hit) begin
          status <= STATUS_UPDATED;
        end else if (have_free) begin
          status <= STATUS_ADDED;
        end else begin
          status <= STATUS_FULL;
        end
      end else if (have_hit) begin
        status        <= STATUS_FOUND;
        found_credits <= hit_credits;
        found_score   <= hit_score;
      end else begin
        status <= STATUS_NOT_FOUND;
      end
    end

    // The old product is formed while the old credits and score leave the
    // sums; the new product likewise, each registered before it is used.
    if (state == ST_MUL_OLD) begin
      product <= PRODUCT_W'(hit_score) * PRODUCT_W'(hit_credits);
    end else if (state == ST_MUL_NEW) begin
      product <= PRODUCT_W'(req_score) * PRODUCT_W'(req_credits);
    end

    // The means never exceed the largest stored score, so the low bits hold
    // the whole quotient whenever the divisor is nonzero.
    if (state == ST_DIV_WAIT && div_done) begin
      if (div_sel) begin
        wmean <= div_quotient[SCORE_W-1:0];
      end else begin
        mean <= div_quotient[SCORE_W-1:0];
      end
    end

    if (state == ST_FINISH && rsp_free) begin
      out_status      <= status;
      out_credits     <= found_credits;
      out_score       <= found_score;
      out_count       <= held_count;
      out_mean_valid  <= (held_count != '0);
      out_mean        <= (held_count != '0) ? mean : '0;
      out_wmean_valid <= (credit_total != '0);
      out_wmean       <= (credit_total != '0) ? wmean : '0;
    end
  end

  assign rsp.valid               = rsp_valid;
  assign rsp.status              = out_status;
  assign rsp.found_credits       = out_credits;
  assign rsp.found_score         = out_score;
  assign rsp.record_count        = out_count;
  assign rsp.mean_score          = out_mean;
  assign rsp.mean_valid          = out_mean_valid;
  assign rsp.weighted_mean_score = out_wmean;
  assign rsp.weighted_valid      = out_wmean_valid;

  // The record count always equals the number of used slots.
  a_count_matches_used: assert property (@(posedge clk) disable iff (rst)
    held_count == COUNT_W'($countones(used)))
    else $error("record count differs from number of used slots");

  // A new record raises the count by exactly one.
  a_add_increments: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE && req_func == FUNC_INSERT && !have_hit && have_free)
    |=> held_count == $past(held_count) + 1'b1)
    else $error("adding a record did not raise the count by one");

  // A full result is only given when every slot is in use.
  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && out_status == STATUS_FULL) |-> out_count == COUNT_W'(TABLE_DEPTH))
    else $error("table full reported with a free slot");

  // The divider is only started while the table state is settled.
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !pipe_valid && !wr_en)
    else $error("division started during scan or write");

endmodule

>>> hdl/krta_record_ram.sv
// Record memory: one write port and one read port with registered read data.
// Depends on krta_pkg for the record type and table depth.
module krta_record_ram import krta_pkg::*; (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  record_t          wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output record_t          rd_data
);

  record_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hdl/krta_divider.sv
// Restoring divider that produces one quotient bit per cycle.
// Depends on krta_pkg for operand widths.
module krta_divider import krta_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  logic                  busy;
  logic [DIV_CNT_W-1:0]  count;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvsr;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W+1:0]  diff;
  logic                  borrow;

  // The quotient register starts out holding the dividend; its top bit shifts
  // into the remainder as each new quotient bit enters at the bottom.
  assign shifted = {rem, quotient[DIVIDEND_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvsr};
  assign borrow  = diff[DIVISOR_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == DIV_CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvsr     <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= borrow ? shifted[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], ~borrow};
    end
  end

endmodule
